// ===== rtl/wmm_pkg.sv =====
// shared types, constants and helpers for the windowed min/max image filter
// no dependencies; used by every module of the block
package wmm_pkg;

    // default geometry limits
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WINDOW_SIZE_DEF = 5;
    localparam int ROW_LIMIT       = 1024;
    localparam int ROW_W           = 10;
    localparam int DIM_W           = 11;

    // reduce modes
    localparam logic FILTER_MIN = 1'b0;
    localparam logic FILTER_MAX = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    // input beat
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0]       filtered_value;
        logic [ROW_W-1:0] centre_column;
        logic [ROW_W-1:0] centre_row;
        logic             frame_last;
    } t_out_beat;

    // line store stage control
    typedef struct packed {
        logic load;
        logic adv;
    } t_lstore_ctl;

    // min or max of two grey levels
    function automatic logic [7:0] pick(input logic mode, input logic [7:0] a,
                                        input logic [7:0] b);
        logic [7:0] res;
        if (mode == FILTER_MAX) begin
            res = (a > b) ? a : b;
        end else begin
            res = (a < b) ? a : b;
        end
        return res;
    endfunction

endpackage

// ===== rtl/wmm_cell.sv =====
// one cell of the horizontal window chain: holds one column extreme
// depends on wmm_pkg for the reduce helper
module wmm_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_mode,
    input  logic [7:0] i_shift_in,
    input  logic [7:0] i_part_in,
    output logic [7:0] o_shift_out,
    output logic [7:0] o_part_out
);

    logic [7:0] r_val;

    // stored column extreme moves on to the neighbor on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 8'd0;
        end else if (i_shift) begin
            r_val <= i_shift_in;
        end
    end

    // running extreme through the chain
    assign o_part_out  = wmm_pkg::pick(i_mode, i_part_in, r_val);
    assign o_shift_out = r_val;

endmodule

// ===== rtl/wmm_vline.sv =====
// line store with registered read and the vertical extreme of each column
// depends on wmm_pkg; the store holds WINDOW_SIZE-1 past pixels per column
module wmm_vline #(
    parameter int MAX_WIDTH   = wmm_pkg::MAX_WIDTH_DEF,
    parameter int WINDOW_SIZE = wmm_pkg::WINDOW_SIZE_DEF
) (
    input  logic                         i_clk,
    input  wmm_pkg::t_lstore_ctl         i_ctl,
    input  logic                         i_mode,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [7:0]                   i_pix,
    output logic [7:0]                   o_vert
);

    localparam int HISTORY = WINDOW_SIZE - 1;
    localparam int LW      = 8 * HISTORY;
    localparam int CW      = $clog2(MAX_WIDTH);

    logic [LW-1:0] mem [MAX_WIDTH];
    logic [LW-1:0] r_rdata;
    logic [LW-1:0] r_fwd_data;
    logic          r_fwd;
    logic [CW-1:0] r_addr;
    logic [7:0]    r_pix;
    logic [LW-1:0] hist;
    logic [LW-1:0] wdata;

    // history of the column in flight, newer write bypasses the memory
    assign hist  = r_fwd ? r_fwd_data : r_rdata;
    assign wdata = {hist[LW-9:0], r_pix};

    // memory write on advance, registered read on load
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            mem[r_addr] <= wdata;
        end
        if (i_ctl.load) begin
            r_rdata <= mem[i_col];
        end
    end

    // stage registers and same-column bypass
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr     <= i_col;
            r_pix      <= i_pix;
            r_fwd      <= i_ctl.adv && (i_col == r_addr);
            r_fwd_data <= wdata;
        end
    end

    // vertical extreme over the new pixel and the history
    always_comb begin
        o_vert = r_pix;
        for (int k = 0; k < HISTORY; k++) begin
            o_vert = wmm_pkg::pick(i_mode, o_vert, hist[8*k +: 8]);
        end
    end

endmodule

// ===== rtl/windowed_min_max_image_filter_unit.sv =====
// top level of the windowed min/max image filter (erosion / dilation), uses wmm_pkg, wmm_vline, wmm_cell
// pipeline: an accepted input beat passes the line store read, vertical extreme and output register
// stages in that order; a stalled output holds every stage
// throughput: one pixel per cycle unless the output stalls; one line store read and write per pixel
// reset: counters cleared, mode min, width 640, height 480, window chain zero;
// the line store is not cleared and needs no clearing pass
module windowed_min_max_image_filter_unit #(
    parameter int MAX_WIDTH   = wmm_pkg::MAX_WIDTH_DEF,
    parameter int WINDOW_SIZE = wmm_pkg::WINDOW_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [wmm_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wmm_pkg::t_in_beat                 i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wmm_pkg::t_out_beat                o_out_beat
);

    localparam int HISTORY = WINDOW_SIZE - 1;
    localparam int HALF    = HISTORY / 2;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int RW      = wmm_pkg::ROW_W;
    localparam int DW      = wmm_pkg::DIM_W;

    // configuration
    logic          r_mode;
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= wmm_pkg::FILTER_MIN;
            r_width  <= wmm_pkg::WIDTH_RST;
            r_height <= wmm_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wmm_pkg::CFG_FILTER_MODE:  r_mode   <= i_cfg_data[0];
                wmm_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                wmm_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry in use
    logic [WW-1:0] w;
    logic [DW-1:0] h;

    always_comb begin
        if (r_width < DW'(WINDOW_SIZE)) begin
            w = WW'(WINDOW_SIZE);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_width);
        end
        if (r_height < DW'(WINDOW_SIZE)) begin
            h = DW'(WINDOW_SIZE);
        end else if (32'(r_height) > 32'(wmm_pkg::ROW_LIMIT)) begin
            h = DW'(wmm_pkg::ROW_LIMIT);
        end else begin
            h = r_height;
        end
    end

    // stage handshake, each stage moves when the next one is free
    logic r_s1_valid, r_s2_valid, r_o_valid;
    logic rdy_out, rdy2, rdy1, accept;

    assign rdy_out    = !r_o_valid || i_out_ready;
    assign rdy2       = !r_s2_valid || rdy_out;
    assign rdy1       = !r_s1_valid || rdy2;
    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;

    // position of the incoming pixel
    logic [CW-1:0] r_col, n_col, cur_col;
    logic [RW-1:0] r_row, n_row, cur_row;
    logic [WW-1:0] col_inc;
    logic [DW-1:0] row_inc;
    logic          col_wrap;

    always_comb begin
        if (i_in_beat.frame_start || (WW'(r_col) >= w)) begin
            cur_col = '0;
        end else begin
            cur_col = r_col;
        end
        if (i_in_beat.frame_start || (DW'(r_row) >= h)) begin
            cur_row = '0;
        end else begin
            cur_row = r_row;
        end
        col_inc  = WW'(cur_col) + WW'(1);
        row_inc  = DW'(cur_row) + DW'(1);
        col_wrap = (col_inc >= w);
        n_col    = col_wrap ? '0 : col_inc[CW-1:0];
        if (!col_wrap) begin
            n_row = cur_row;
        end else if (row_inc >= h) begin
            n_row = '0;
        end else begin
            n_row = row_inc[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // output tags of the incoming pixel
    logic            emit_in, last_in;
    logic [31:0]     ccol_full;
    logic [RW-1:0]   ccol_in, crow_in;

    assign emit_in   = (WW'(cur_col) >= WW'(HISTORY)) && (cur_row >= RW'(HISTORY));
    assign last_in   = (DW'(cur_row) == h - DW'(1)) && (WW'(cur_col) == w - WW'(1));
    assign ccol_full = 32'(cur_col) - 32'(HALF);
    assign ccol_in   = ccol_full[RW-1:0];
    assign crow_in   = cur_row - RW'(HALF);

    // stage 1: line store read, stage 2: vertical extreme
    logic          r_s1_emit, r_s1_last, r_s2_emit, r_s2_last;
    logic [RW-1:0] r_s1_ccol, r_s1_crow, r_s2_ccol, r_s2_crow;
    logic [7:0]    r_s2_vert, vert;
    logic          s1_adv, s2_adv;
    wmm_pkg::t_lstore_ctl lctl;

    assign s1_adv    = r_s1_valid && rdy2;
    assign s2_adv    = r_s2_valid && rdy_out;
    assign lctl.load = accept;
    assign lctl.adv  = s1_adv;

    wmm_vline #(
        .MAX_WIDTH   (MAX_WIDTH),
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_vline (
        .i_clk  (i_clk),
        .i_ctl  (lctl),
        .i_mode (r_mode),
        .i_col  (cur_col),
        .i_pix  (i_in_beat.pixel_value),
        .o_vert (vert)
    );

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy_out) begin
                r_o_valid <= r_s2_valid && r_s2_emit;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit_in;
            r_s1_last <= last_in;
            r_s1_ccol <= ccol_in;
            r_s1_crow <= crow_in;
        end
        if (s1_adv) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
            r_s2_ccol <= r_s1_ccol;
            r_s2_crow <= r_s1_crow;
            r_s2_vert <= vert;
        end
    end

    // horizontal window: chain of cells holding past column extremes
    logic [7:0] shift_chain [HISTORY+1];
    logic [7:0] part_chain  [HISTORY+1];

    assign shift_chain[0] = r_s2_vert;
    assign part_chain[0]  = r_s2_vert;

    for (genvar g = 0; g < HISTORY; g++) begin : g_cell
        wmm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (s2_adv),
            .i_mode      (r_mode),
            .i_shift_in  (shift_chain[g]),
            .i_part_in   (part_chain[g]),
            .o_shift_out (shift_chain[g+1]),
            .o_part_out  (part_chain[g+1])
        );
    end

    // output register
    wmm_pkg::t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out.filtered_value <= part_chain[HISTORY];
            r_out.centre_column  <= r_s2_ccol;
            r_out.centre_row     <= r_s2_crow;
            r_out.frame_last     <= r_s2_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== test/wmm_checker.sv =====
// scoreboard for the windowed min/max image filter: mirrors the filter state,
// predicts each output beat and compares it with what the block sends
// depends on wmm_pkg
module wmm_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [wmm_pkg::DIM_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  wmm_pkg::t_in_beat         i_in_beat,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  wmm_pkg::t_out_beat        i_out_beat,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW         = wmm_pkg::DIM_W;
    localparam int RW         = wmm_pkg::ROW_W;
    localparam int MAXW       = wmm_pkg::MAX_WIDTH_DEF;
    localparam int WIN        = wmm_pkg::WINDOW_SIZE_DEF;
    localparam int HIST       = WIN - 1;
    localparam int HALF       = HIST / 2;

    // mirrored configuration and position
    logic          mode_q;
    logic [DW-1:0] width_q;
    logic [DW-1:0] height_q;
    int            col_pos;
    int            row_pos;

    // per-column pixel history and the run of column extremes on the current line
    logic [7:0] column_hist [MAXW][HIST];
    logic [7:0] extreme_run [HIST];

    // window results still owed by the block, oldest first
    wmm_pkg::t_out_beat owed_windows [$];
    int                 fail_n = 0;

    assign o_fail_count = fail_n;

    function automatic int usable_dim(input logic [DW-1:0] raw, input int hi);
        int v;
        v = int'(raw);
        if (v < WIN) begin
            v = WIN;
        end else if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    function automatic logic [7:0] keep_extreme(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        if (mode_q == wmm_pkg::FILTER_MAX) begin
            r = (a > b) ? a : b;
        end else begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
        fail_n++;
    endtask

    // one pixel: vertical extreme over the column history, then horizontal
    // extreme over the last window of column extremes
    task automatic predict_window(input wmm_pkg::t_in_beat px);
        int                 w;
        int                 h;
        int                 col;
        int                 row;
        int                 k;
        logic [7:0]         vert;
        logic [7:0]         win;
        wmm_pkg::t_out_beat owed;
        w = usable_dim(width_q, MAXW);
        h = usable_dim(height_q, wmm_pkg::ROW_LIMIT);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;

        vert = px.pixel_value;
        for (k = 0; k < HIST; k++) vert = keep_extreme(vert, column_hist[col][k]);
        for (k = HIST - 1; k > 0; k--) column_hist[col][k] = column_hist[col][k-1];
        column_hist[col][0] = px.pixel_value;

        win = vert;
        for (k = 0; k < HIST; k++) win = keep_extreme(win, extreme_run[k]);
        for (k = HIST - 1; k > 0; k--) extreme_run[k] = extreme_run[k-1];
        extreme_run[0] = vert;

        // only centres whose whole window is inside the image
        if (row >= HIST && col >= HIST) begin
            owed.filtered_value = win;
            owed.centre_column  = RW'(col - HALF);
            owed.centre_row     = RW'(row - HALF);
            owed.frame_last     = (row == h - 1) && (col == w - 1);
            owed_windows.insert(owed_windows.size(), owed);
        end

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic check_window(input wmm_pkg::t_out_beat got);
        wmm_pkg::t_out_beat want;
        if (owed_windows.size() == 0) begin
            report_mismatch("beat with none owed", 32'(got.filtered_value), 32'hffff_ffff);
            return;
        end
        want = owed_windows.pop_front();
        if (got.filtered_value !== want.filtered_value)
            report_mismatch("filtered_value", 32'(got.filtered_value),
                            32'(want.filtered_value));
        if (got.centre_column !== want.centre_column)
            report_mismatch("centre_column", 32'(got.centre_column),
                            32'(want.centre_column));
        if (got.centre_row !== want.centre_row)
            report_mismatch("centre_row", 32'(got.centre_row), 32'(want.centre_row));
        if (got.frame_last !== want.frame_last)
            report_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
    endtask

    // watch both channels and the register port on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q   = wmm_pkg::FILTER_MIN;
            width_q  = wmm_pkg::WIDTH_RST;
            height_q = wmm_pkg::HEIGHT_RST;
            col_pos  = 0;
            row_pos  = 0;
            for (int c = 0; c < MAXW; c++) begin
                for (int k = 0; k < HIST; k++) column_hist[c][k] = 8'd0;
            end
            for (int k = 0; k < HIST; k++) extreme_run[k] = 8'd0;
            owed_windows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wmm_pkg::CFG_FILTER_MODE:  mode_q   = i_cfg_data[0];
                    wmm_pkg::CFG_IMAGE_WIDTH:  width_q  = i_cfg_data;
                    wmm_pkg::CFG_IMAGE_HEIGHT: height_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_window(i_in_beat);
            if (i_out_valid && i_out_ready) check_window(i_out_beat);
        end
        o_pending <= owed_windows.size();
    end

endmodule

// ===== test/tb_top.sv =====
// top of the windowed min/max filter testbench: clock, reset, register setup,
// pixel stimulus and back-pressure; the verdict comes from wmm_checker
// depends on wmm_pkg, wmm_checker and windowed_min_max_image_filter_unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW            = wmm_pkg::DIM_W;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1300;
    localparam int WIDE_PIXELS   = 1026;
    localparam int WIDE_TAIL     = 18;
    localparam int TALL_PIXELS   = 60;
    localparam int IDLE_PCT      = 21;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = wmm_pkg::CFG_FILTER_MODE;
    logic [DW-1:0]      cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    wmm_pkg::t_in_beat  in_beat = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    wmm_pkg::t_out_beat out_beat;
    logic               quiet = 1'b0;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 sent_count = 0;

    windowed_min_max_image_filter_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    wmm_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // output back-pressure, off during quiet stretches
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int usable_dim(input int raw, input int hi);
        int v;
        v = raw;
        if (v < wmm_pkg::WINDOW_SIZE_DEF) begin
            v = wmm_pkg::WINDOW_SIZE_DEF;
        end else if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    // grey level biased toward the ends of the range
    function automatic logic [7:0] random_grey();
        int sel;
        logic [7:0] g;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            g = 8'h00;
        end else if (sel == 1) begin
            g = 8'hff;
        end else begin
            g = 8'($urandom_range(0, 255));
        end
        return g;
    endfunction

    // program all three registers; only called while the block is idle
    task automatic program_filter(input logic mode, input logic [DW-1:0] w_raw,
                                  input logic [DW-1:0] h_raw);
        cfg_we    <= 1'b1;
        cfg_index <= wmm_pkg::CFG_FILTER_MODE;
        cfg_data  <= DW'(mode);
        @(posedge clk);
        cfg_index <= wmm_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= w_raw;
        @(posedge clk);
        cfg_index <= wmm_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] grey, input logic first);
        wmm_pkg::t_in_beat b;
        b.pixel_value = grey;
        b.frame_start = first;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // stop sending until every owed window is back, then let the pipe settle
    task automatic drain_windows();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one whole frame at a fixed geometry
    task automatic run_frame(input logic mode, input logic [DW-1:0] w_raw,
                             input logic [DW-1:0] h_raw);
        int frame_len;
        frame_len = usable_dim(int'(w_raw), wmm_pkg::MAX_WIDTH_DEF) *
                    usable_dim(int'(h_raw), wmm_pkg::ROW_LIMIT);
        program_filter(mode, w_raw, h_raw);
        for (int i = 0; i < frame_len; i++) send_pixel(random_grey(), i == 0);
        drain_windows();
    endtask

    initial begin
        int            phase;
        int            n_pix;
        int            frame_len;
        int            pos;
        logic          mode;
        logic          first;
        logic [7:0]    grey;
        logic [DW-1:0] w_raw;
        logic [DW-1:0] h_raw;

        phase = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame, out-of-range geometry clamped up, dilation:
        // bright pixel in the oldest corner, dark one at the newest
        program_filter(wmm_pkg::FILTER_MAX, 11'd0, 11'd3);
        for (int i = 0; i < 25; i++) begin
            if (i == 0) begin
                grey = 8'hff;
            end else if (i == 24) begin
                grey = 8'h00;
            end else begin
                grey = 8'(i * 9 + 3);
            end
            send_pixel(grey, i == 0);
        end
        drain_windows();

        // widest line, clamped down from all ones, no idling on either side:
        // one full line and two more pixels
        quiet <= 1'b1;
        program_filter(wmm_pkg::FILTER_MIN, 11'h7ff, 11'd5);
        for (int i = 0; i < WIDE_PIXELS; i++) send_pixel(random_grey(), i == 0);
        drain_windows();

        // same frame carried on at width 5, so the row reached above shows
        // up in the single window at its end
        program_filter(wmm_pkg::FILTER_MIN, 11'd5, 11'd5);
        for (int i = 0; i < WIDE_TAIL; i++) send_pixel(random_grey(), 1'b0);
        drain_windows();
        quiet <= 1'b0;

        // fill the history of every column a random geometry can reach
        run_frame(wmm_pkg::FILTER_MAX, 11'd12, 11'd5);

        // tall frame clamped down from all ones, first rows only
        program_filter(wmm_pkg::FILTER_MAX, 11'd5, 11'h7ff);
        for (int i = 0; i < TALL_PIXELS; i++) send_pixel(random_grey(), i == 0);
        drain_windows();

        // random small geometries; a phase may start mid-frame, since every
        // column it can reach has a full history from the frame above
        while (sent_count < ITEM_TARGET) begin
            mode  = (phase % 2 == 0) ? wmm_pkg::FILTER_MIN : wmm_pkg::FILTER_MAX;
            w_raw = ($urandom_range(0, 5) == 0) ? DW'($urandom_range(0, 4))
                                                : DW'($urandom_range(5, 12));
            h_raw = ($urandom_range(0, 5) == 0) ? DW'($urandom_range(0, 4))
                                                : DW'($urandom_range(5, 10));
            program_filter(mode, w_raw, h_raw);
            frame_len = usable_dim(int'(w_raw), wmm_pkg::MAX_WIDTH_DEF) *
                        usable_dim(int'(h_raw), wmm_pkg::ROW_LIMIT);
            n_pix = $urandom_range(30, 60);
            pos   = 0;
            if (phase == 1) quiet <= 1'b1;
            for (int i = 0; i < n_pix; i++) begin
                // mostly whole frames; rarely a restart in the middle
                if (i == 0 || pos == 0) begin
                    first = $urandom_range(0, 1);
                end else begin
                    first = ($urandom_range(0, 149) == 0);
                end
                if (first) pos = 0;
                send_pixel(random_grey(), first);
                pos = (pos + 1) % frame_len;
                if (phase == 0 && i == 20) drain_windows();
            end
            drain_windows();
            if (phase == 1) quiet <= 1'b0;
            phase++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
